### rtl/sbcm_pkg.sv
// ----------------------------------------------------------------------------
// sbcm_pkg: shared types and constants of the spectrum bin colour map
// Field widths, internal datapath widths, the threshold table and the ARGB
// colour table used by the power pipeline and the top level.
// ----------------------------------------------------------------------------
package sbcm_pkg;

  // Width of the real and imaginary bin fields.
  localparam int BinWidth    = 32;
  // Magnitudes are squared as two halves: low half and high half.
  localparam int HalfLo      = (BinWidth + 1) / 2;
  localparam int HalfHi      = BinWidth - HalfLo;
  localparam int SqWidth     = 2 * BinWidth;
  // Sums at or above 2^SumClip saturate the level whenever the gain is non-zero.
  localparam int SumClip     = 72;
  localparam int SumExt      = (SqWidth > SumClip) ? SqWidth : SumClip + 1;
  localparam int GainWidth   = 24;
  localparam int GainSqWidth = 2 * GainWidth;
  localparam int Piece       = 24;
  localparam int NumSumPcs   = SumClip / Piece;
  localparam int NumGainPcs  = GainSqWidth / Piece;
  localparam int ProdWidth   = 2 * Piece;
  localparam int LhsWidth    = SumClip + GainSqWidth;
  // The low bits of the scaled power never affect a threshold decision.
  localparam int LevelShift  = 32;
  localparam int LevelWidth  = 41;
  localparam int ThrSqWidth  = LevelWidth - 1;
  localparam int ThrWidth    = 20;
  localparam int NumColors   = 96;
  localparam int LastIndex   = 95;
  localparam int IndexWidth  = 7;
  localparam int ColorWidth  = 32;

  // Gain squared after reset: gain of 1.0 in Q8.16.
  localparam logic [GainSqWidth-1:0] GainSqReset = 48'h0001_0000_0000;

  typedef struct packed {
    logic signed [BinWidth-1:0] bin_real;
    logic signed [BinWidth-1:0] bin_imag;
  } in_t;

  typedef struct packed {
    logic [ColorWidth-1:0] color_word;
    logic [IndexWidth-1:0] color_index;
  } out_t;

  // Saturated power level: the top bit flags a level of 2^(LevelWidth-1) or more.
  typedef logic [LevelWidth-1:0] level_t;

  localparam logic [ThrWidth-1:0] ThrTab [NumColors] = '{
    20'd16, 20'd17, 20'd20, 20'd22, 20'd25, 20'd28, 20'd31, 20'd35,
    20'd40, 20'd45, 20'd50, 20'd56, 20'd63, 20'd71, 20'd80, 20'd89,
    20'd100, 20'd113, 20'd127, 20'd142, 20'd160, 20'd179, 20'd201, 20'd226,
    20'd253, 20'd284, 20'd319, 20'd358, 20'd401, 20'd450, 20'd505, 20'd567,
    20'd636, 20'd714, 20'd801, 20'd899, 20'd1009, 20'd1132, 20'd1270, 20'd1426,
    20'd1600, 20'd1795, 20'd2014, 20'd2260, 20'd2535, 20'd2845, 20'd3192, 20'd3581,
    20'd4019, 20'd4509, 20'd5059, 20'd5677, 20'd6369, 20'd7146, 20'd8018, 20'd8997,
    20'd10095, 20'd11327, 20'd12709, 20'd14260, 20'd16000, 20'd17952, 20'd20142,
    20'd22600, 20'd25358, 20'd28452, 20'd31924, 20'd35819, 20'd40190, 20'd45094,
    20'd50596, 20'd56770, 20'd63697, 20'd71469, 20'd80189, 20'd89974, 20'd100953,
    20'd113271, 20'd127092, 20'd142600, 20'd160000, 20'd179523, 20'd201427,
    20'd226005, 20'd253582, 20'd284524, 20'd319242, 20'd358195, 20'd401901,
    20'd450940, 20'd505964, 20'd567701, 20'd636971, 20'd714693, 20'd801899,
    20'd899745
  };

  localparam logic [ColorWidth-1:0] ColorTab [NumColors] = '{
    32'hFF000000, 32'hFF000010, 32'hFF000020, 32'hFF000030,
    32'hFF000040, 32'hFF000050, 32'hFF000060, 32'hFF000070,
    32'hFF000080, 32'hFF000090, 32'hFF0000A0, 32'hFF0000B0,
    32'hFF0000C0, 32'hFF0000D0, 32'hFF0000E0, 32'hFF0000F0,
    32'hFF0000FF, 32'hFF0010FF, 32'hFF0020FF, 32'hFF0030FF,
    32'hFF0040FF, 32'hFF0050FF, 32'hFF0060FF, 32'hFF0070FF,
    32'hFF0080FF, 32'hFF0090FF, 32'hFF00A0FF, 32'hFF00B0FF,
    32'hFF00C0FF, 32'hFF00D0FF, 32'hFF00E0FF, 32'hFF00F0FF,
    32'hFF00FFFF, 32'hFF00FFF0, 32'hFF00FFE0, 32'hFF00FFD0,
    32'hFF00FFC0, 32'hFF00FFB0, 32'hFF00FFA0, 32'hFF00FF90,
    32'hFF00FF80, 32'hFF00FF70, 32'hFF00FF60, 32'hFF00FF50,
    32'hFF00FF40, 32'hFF00FF30, 32'hFF00FF20, 32'hFF00FF10,
    32'hFF00FF00, 32'hFF10FF00, 32'hFF20FF00, 32'hFF30FF00,
    32'hFF40FF00, 32'hFF50FF00, 32'hFF60FF00, 32'hFF70FF00,
    32'hFF80FF00, 32'hFF90FF00, 32'hFFA0FF00, 32'hFFB0FF00,
    32'hFFC0FF00, 32'hFFD0FF00, 32'hFFE0FF00, 32'hFFF0FF00,
    32'hFFFFFF00, 32'hFFFFF000, 32'hFFFFE000, 32'hFFFFD000,
    32'hFFFFC000, 32'hFFFFB000, 32'hFFFFA000, 32'hFFFF9000,
    32'hFFFF8000, 32'hFFFF7000, 32'hFFFF6000, 32'hFFFF5000,
    32'hFFFF4000, 32'hFFFF3000, 32'hFFFF2000, 32'hFFFF1000,
    32'hFFFF0000, 32'hFFFF0010, 32'hFFFF0020, 32'hFFFF0030,
    32'hFFFF0040, 32'hFFFF0050, 32'hFFFF0060, 32'hFFFF0070,
    32'hFFFF0080, 32'hFFFF0090, 32'hFFFF00A0, 32'hFFFF00B0,
    32'hFFFF00C0, 32'hFFFF00D0, 32'hFFFF00E0, 32'hFFFF00F0
  };

endpackage

### rtl/spectrum_bin_color_map.sv
// ----------------------------------------------------------------------------
// spectrum_bin_color_map: waterfall colour for one complex spectrum bin
// Scales the bin magnitude by the display gain, finds the first colour
// threshold not exceeded and returns the index and its ARGB word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one bin (real, imaginary)
//   per transaction. Output channel: out_valid_o / out_stall_i carry the
//   colour word and colour index of that bin, in the order taken.
//   The gain (unsigned Q8.16) is written through gain_we_i / gain_wdata_i;
//   the user must write it only while no transaction is in flight, as the
//   block itself does not enforce this. Its square is held internally.
//   Throughput: one bin per cycle while the output is not stalled, set by
//   a ten-stage pipeline in which every multiplier is at most 24 by 24 bits.
//   Reset empties the pipeline and sets the gain to 1.0.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_stall_o is raised; nothing is lost or repeated. Bubbles
//   drain freely while the output register is empty or being taken.
// ----------------------------------------------------------------------------
module spectrum_bin_color_map (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sbcm_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sbcm_pkg::out_t                      out_data_o,
  input  logic                                gain_we_i,
  input  logic [sbcm_pkg::GainWidth-1:0]      gain_wdata_i
);

  localparam int NT = sbcm_pkg::LastIndex;
  localparam int IW = sbcm_pkg::IndexWidth;
  localparam int TW = 1 << IW;

  logic                                  adv;
  logic [sbcm_pkg::GainSqWidth-1:0]      gain_sq_q, gain_sq_d;
  logic                                  pwr_valid;
  sbcm_pkg::level_t                      pwr_level;
  logic [NT-1:0]                         ge_q, ge_d;
  logic                                  ge_valid_q;
  logic [IW-1:0]                         idx_q, idx_d;
  logic                                  idx_valid_q;
  logic                                  out_valid_q;
  sbcm_pkg::out_t                        out_q, out_d;

  // The pipeline moves unless a waiting result is stalled.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Gain register, kept as its square.
  assign gain_sq_d = sbcm_pkg::GainSqWidth'(gain_wdata_i)
                   * sbcm_pkg::GainSqWidth'(gain_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_sq_q <= sbcm_pkg::GainSqReset;
    end else if (gain_we_i) begin
      gain_sq_q <= gain_sq_d;
    end
  end

  // Stages 1 to 7: saturated scaled power level.
  sbcm_power u_power (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (in_valid_i),
    .bin_i     (in_data_i),
    .gain_sq_i (gain_sq_q),
    .valid_o   (pwr_valid),
    .level_o   (pwr_level)
  );

  // Stage 8: compare in parallel against (threshold + 1) squared for all but the last threshold.
  for (genvar k = 0; k < NT; k++) begin : g_cmp
    localparam logic [sbcm_pkg::ThrSqWidth-1:0] ThrPlus =
      sbcm_pkg::ThrSqWidth'(sbcm_pkg::ThrTab[k]) + 1;
    localparam logic [sbcm_pkg::ThrSqWidth-1:0] ThrSq = ThrPlus * ThrPlus;
    assign ge_d[k] = pwr_level >= {1'b0, ThrSq};
  end

  // Stage 9: the compare vector is a thermometer code; convert its length.
  always_comb begin
    logic [TW-1:0] therm;
    logic [IW-1:0] step;
    therm = TW'(ge_q);
    idx_d = '0;
    for (int b = IW - 1; b >= 0; b--) begin
      step = IW'(1 << b);
      if (therm[idx_d + step - {{(IW-1){1'b0}}, 1'b1}]) begin
        idx_d = idx_d + step;
      end
    end
  end

  // Stage 10: colour lookup into the output register.
  assign out_d.color_index = idx_q;
  assign out_d.color_word  = sbcm_pkg::ColorTab[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ge_valid_q  <= 1'b0;
      idx_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      ge_valid_q  <= pwr_valid;
      idx_valid_q <= ge_valid_q;
      out_valid_q <= idx_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ge_q  <= ge_d;
      idx_q <= idx_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/sbcm_power.sv
// ----------------------------------------------------------------------------
// sbcm_power: seven-stage scaled power pipeline
// Forms (re^2 + im^2) * gain^2 from partial products of at most 24 by 24
// bits and reduces it to a saturated level for the threshold compare.
// ----------------------------------------------------------------------------
module sbcm_power (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  sbcm_pkg::in_t                        bin_i,
  input  logic [sbcm_pkg::GainSqWidth-1:0]     gain_sq_i,
  output logic                                 valid_o,
  output sbcm_pkg::level_t                     level_o
);

  localparam int W   = sbcm_pkg::BinWidth;
  localparam int HL  = sbcm_pkg::HalfLo;
  localparam int HH  = sbcm_pkg::HalfHi;
  localparam int SQ  = sbcm_pkg::SqWidth;
  localparam int SC  = sbcm_pkg::SumClip;
  localparam int SX  = sbcm_pkg::SumExt;
  localparam int PC  = sbcm_pkg::Piece;
  localparam int NS  = sbcm_pkg::NumSumPcs;
  localparam int NG  = sbcm_pkg::NumGainPcs;
  localparam int PW  = sbcm_pkg::ProdWidth;
  localparam int LW  = sbcm_pkg::LhsWidth;
  localparam int LS  = sbcm_pkg::LevelShift;
  localparam int VW  = sbcm_pkg::LevelWidth;
  localparam int NumStages = 7;

  // Valid bits travel alongside the data, one per stage.
  logic [NumStages-1:0] valid_q, valid_d;

  // Stage 1: magnitudes of both parts; the most negative value maps exactly.
  logic [W-1:0] mag_q [2], mag_d [2];
  // Stage 2: partial products of each square.
  logic [2*HH-1:0]   pp_hh_q [2], pp_hh_d [2];
  logic [HH+HL-1:0]  pp_hl_q [2], pp_hl_d [2];
  logic [2*HL-1:0]   pp_ll_q [2], pp_ll_d [2];
  // Stage 3: the two squares.
  logic [SQ-1:0]     sq_q [2], sq_d [2];
  // Stage 4: clipped sum and its overflow flag.
  logic [SX-1:0]     sum_ext;
  logic [SC-1:0]     clip_q, clip_d;
  logic              big_q, big_d;
  // Stage 5: products of the sum pieces with the gain-squared pieces.
  logic [PW-1:0]     prod_q [NS][NG], prod_d [NS][NG];
  logic              big5_q, big5_d;
  // Stage 6: partial sums of products that share a weight.
  logic [PW:0]       mid1_q, mid1_d, mid2_q, mid2_d;
  logic [PW-1:0]     low_q, low_d, top_q, top_d;
  logic              big6_q, big6_d;
  // Stage 7: saturated level.
  logic [LW-1:0]     lhs;
  sbcm_pkg::level_t  level_q, level_d;

  assign valid_d = {valid_q[NumStages-2:0], valid_i};

  // Stages 1 to 3: magnitude, split squaring and recombination.
  always_comb begin
    logic [W-1:0] raw [2];
    raw[0] = $unsigned(bin_i.bin_real);
    raw[1] = $unsigned(bin_i.bin_imag);
    for (int l = 0; l < 2; l++) begin
      mag_d[l]   = raw[l][W-1] ? (~raw[l] + {{(W-1){1'b0}}, 1'b1}) : raw[l];
      pp_hh_d[l] = (2 * HH)'(mag_q[l][W-1:HL]) * (2 * HH)'(mag_q[l][W-1:HL]);
      pp_hl_d[l] = (HH + HL)'(mag_q[l][W-1:HL]) * (HH + HL)'(mag_q[l][HL-1:0]);
      pp_ll_d[l] = (2 * HL)'(mag_q[l][HL-1:0]) * (2 * HL)'(mag_q[l][HL-1:0]);
      sq_d[l]    = (SQ'(pp_hh_q[l]) << (2 * HL)) + (SQ'(pp_hl_q[l]) << (HL + 1))
                 + SQ'(pp_ll_q[l]);
    end
  end

  // Stage 4: sum of squares, clipped where the level saturates anyway.
  assign sum_ext = SX'(sq_q[0]) + SX'(sq_q[1]);
  assign clip_d  = sum_ext[SC-1:0];
  assign big_d   = |sum_ext[SX-1:SC];

  // Stage 5: piecewise product with the gain squared.
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      for (int j = 0; j < NG; j++) begin
        prod_d[i][j] = PW'(clip_q[i*PC +: PC]) * PW'(gain_sq_i[j*PC +: PC]);
      end
    end
  end
  assign big5_d = big_q & (gain_sq_i != '0);

  // Stage 6: combine products of equal weight.
  assign mid1_d = (PW + 1)'(prod_q[1][0]) + (PW + 1)'(prod_q[0][1]);
  assign mid2_d = (PW + 1)'(prod_q[2][0]) + (PW + 1)'(prod_q[1][1]);
  assign low_d  = prod_q[0][0];
  assign top_d  = prod_q[2][1];
  assign big6_d = big5_q;

  // Stage 7: full product, dropping the low bits and saturating the top.
  assign lhs = LW'(low_q) + (LW'(mid1_q) << PC) + (LW'(mid2_q) << (2 * PC))
             + (LW'(top_q) << (3 * PC));
  assign level_d = {big6_q | (|lhs[LW-1:LS+VW-1]), lhs[LS+VW-2:LS]};

  // Valid bits are the only control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  // Payload registers of all stages advance together.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        mag_q[l]   <= mag_d[l];
        pp_hh_q[l] <= pp_hh_d[l];
        pp_hl_q[l] <= pp_hl_d[l];
        pp_ll_q[l] <= pp_ll_d[l];
        sq_q[l]    <= sq_d[l];
      end
      clip_q <= clip_d;
      big_q  <= big_d;
      prod_q <= prod_d;
      big5_q <= big5_d;
      mid1_q <= mid1_d;
      mid2_q <= mid2_d;
      low_q  <= low_d;
      top_q  <= top_d;
      big6_q <= big6_d;
      level_q <= level_d;
    end
  end

  assign valid_o = valid_q[NumStages-1];
  assign level_o = level_q;

endmodule
